/* sv/apre_pkg.sv */
// shared widths, register indexes and state codes of the audio pump rate estimator
package apre_pkg;

  localparam int FREQ_W     = 40;
  localparam int RATE_W     = 19;
  localparam int COUNT_W    = 16;
  localparam int ELAPSED_W  = 32;
  localparam int AVG_W      = 24;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FREQ_W-1:0]  TICK_FREQ_RST   = FREQ_W'(1000000);
  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = RATE_W'(48000);
  localparam logic [COUNT_W-1:0] NOMINAL_RST     = COUNT_W'(800);
  localparam logic [COUNT_W-1:0] CEILING_RST     = COUNT_W'(1600);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_FREQ   = 2'd0,
    CFG_SAMPLE_RATE = 2'd1,
    CFG_NOMINAL     = 2'd2,
    CFG_CEILING     = 2'd3
  } cfg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_CLAMP = 8'b0000_1000,
    ST_UPD   = 8'b0001_0000,
    ST_LOADA = 8'b0010_0000,
    ST_ALIGN = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

endpackage

/* sv/apre_in_if.sv */
// input channel carrying the elapsed tick count of one item
interface apre_in_if import apre_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, output elapsed, input ready);
  modport sink (input valid, input elapsed, output ready);
endinterface

/* sv/apre_out_if.sv */
// output channel carrying the samples due on one pump
interface apre_out_if import apre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] pump_samples;

  modport source (output valid, output pump_samples, input ready);
  modport sink (input valid, input pump_samples, output ready);
endinterface

/* sv/audio_pump_rate_estimator.sv */
// top level of the audio pump rate estimator
//
// usage:
//   in_i carries one item per pump: the timer ticks elapsed since the last pump.
//   out_o returns one item per input item: the samples to produce on that pump.
//   cfg_we_i/cfg_idx_i/cfg_data_i write tick frequency, sample rate, nominal and
//   ceiling counts, taken at any edge with cfg_we_i high; the user must write
//   them only while the block is idle, as the block itself does not enforce it.
//   the samples due are found by one 32x19 multiply and one restoring divider
//   that retires one quotient bit per cycle: 60 steps for the tick division; the
//   alignment grid uses a combinational reciprocal multiply. in_i.ready rises as
//   the result is loaded, so no new item is taken before the last one's result
//   is loaded. with a zero tick frequency or sample rate the nominal count goes
//   straight to ST_OUT and the average is left untouched.
//   a result waits in the output register while out_o.ready is low; the block
//   takes the next item meanwhile and holds its own result until the slot frees.
//   reset restores the register defaults and empties the moving average.
module audio_pump_rate_estimator import apre_pkg::*; #(
  parameter int ALIGN_SAMPLES = 16,
  parameter int SMOOTH_SHIFT  = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FREQ_W-1:0]    cfg_data_i,
  apre_in_if.sink              in_i,
  apre_out_if.source           out_o
);

  localparam int PROD_W = ELAPSED_W + RATE_W;
  localparam int DVD_W  = PROD_W + FRAC_W + 1;
  localparam int DIV_W  = FREQ_W;
  localparam int ALN_W  = AVG_W - FRAC_W + 2;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int ALN_SH = ALN_W + $clog2(ALIGN_SAMPLES);
  localparam int RCP_W  = ALN_SH + 1;
  localparam int MUL_W  = ALN_W + RCP_W;
  localparam logic [RCP_W-1:0] ALN_RCP =
    RCP_W'(((1 << ALN_SH) + ALIGN_SAMPLES - 1) / ALIGN_SAMPLES);

  logic [FREQ_W-1:0]  freq_q;
  logic [RATE_W-1:0]  rate_q;
  logic [COUNT_W-1:0] nom_q;
  logic [COUNT_W-1:0] ceil_q;
  logic [COUNT_W-1:0] ceil_eff;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [AVG_W-1:0]   avg_q, avg_d;
  logic               out_valid_q, out_valid_d;

  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [DIV_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]   div_q, div_d;
  logic [AVG_W-1:0]   obs_q, obs_d;
  logic [COUNT_W-1:0] res_q, res_d;
  logic [COUNT_W-1:0] out_data_q;

  logic [PROD_W-1:0]  prod;
  logic [DIV_W:0]     rem_sh;
  logic               div_ge;
  logic [DIV_W:0]     rem_nx;
  logic [AVG_W-1:0]   lo_q8;
  logic [AVG_W-1:0]   hi_q8;
  logic [AVG_W:0]     avg_rnd;
  logic [ALN_W-1:0]   aln_v;
  logic [MUL_W-1:0]   aln_prod;
  logic [ALN_W-1:0]   aln_quo;
  logic [ALN_W-1:0]   aligned;
  logic               in_acc;
  logic               out_load;
  logic               rate_zero;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= TICK_FREQ_RST;
      rate_q <= SAMPLE_RATE_RST;
      nom_q  <= NOMINAL_RST;
      ceil_q <= CEILING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_FREQ:   freq_q <= cfg_data_i;
        CFG_SAMPLE_RATE: rate_q <= cfg_data_i[RATE_W-1:0];
        CFG_NOMINAL:     nom_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_CEILING:     ceil_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ceil_eff  = (ceil_q < nom_q) ? nom_q : ceil_q;
  assign lo_q8     = {nom_q, {FRAC_W{1'b0}}};
  assign hi_q8     = {ceil_eff, {FRAC_W{1'b0}}};
  assign rate_zero = (freq_q == '0) || (rate_q == '0);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  assign prod = PROD_W'(in_i.elapsed) * PROD_W'(rate_q);

  // restoring divider step
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge = (rem_sh >= {1'b0, div_q});
  assign rem_nx = div_ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

  assign avg_rnd  = {1'b0, avg_q} + (AVG_W + 1)'(1 << (FRAC_W - 1));
  assign aln_v    = ALN_W'(avg_rnd[AVG_W:FRAC_W]) + ALN_W'(ALIGN_SAMPLES / 2);
  assign aln_prod = MUL_W'(aln_v) * MUL_W'(ALN_RCP);
  assign aln_quo  = aln_prod[ALN_SH +: ALN_W];
  assign aligned  = obs_q[ALN_W-1:0] * ALN_W'(ALIGN_SAMPLES);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    avg_d       = avg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    obs_d       = obs_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (rate_zero) begin
            res_d   = nom_q;
            state_d = ST_OUT;
          end else begin
            dvd_d   = DVD_W'(prod);
            if (avg_q == '0) begin
              avg_d = lo_q8;
            end
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        dvd_d   = {dvd_q[DVD_W-FRAC_W-1:0], {FRAC_W{1'b0}}} + DVD_W'(freq_q >> 1);
        div_d   = freq_q;
        rem_d   = '0;
        cnt_d   = CNT_W'(DVD_W);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dvd_d = {dvd_q[DVD_W-2:0], div_ge};
        rem_d = rem_nx[DIV_W-1:0];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (dvd_q < DVD_W'(lo_q8)) begin
          obs_d = lo_q8;
        end else if (dvd_q > DVD_W'(hi_q8)) begin
          obs_d = hi_q8;
        end else begin
          obs_d = dvd_q[AVG_W-1:0];
        end
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (obs_q >= avg_q) begin
          avg_d = avg_q + ((obs_q - avg_q) >> SMOOTH_SHIFT);
        end else begin
          avg_d = avg_q - ((avg_q - obs_q) >> SMOOTH_SHIFT);
        end
        state_d = ST_LOADA;
      end
      ST_LOADA: begin
        obs_d   = AVG_W'(aln_quo);
        state_d = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (aligned < ALN_W'(nom_q)) begin
          res_d = nom_q;
        end else if (aligned > ALN_W'(ceil_eff)) begin
          res_d = ceil_eff;
        end else begin
          res_d = aligned[COUNT_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
    obs_q <= obs_d;
    res_q <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pump_samples = out_data_q;

endmodule

/* sv/apre_checker.sv */
// port-level checks of the audio pump rate estimator and their binding
module apre_checker import apre_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COUNT_W-1:0] pump_samples_i
);

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // a new result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a busy cycle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(pump_samples_i))
    else $error("output item changed while stalled");

endmodule

bind audio_pump_rate_estimator apre_checker u_apre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .pump_samples_i (out_o.pump_samples)
);
